### rtl/cfp_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cfp_pkg
// Shared types, codes and defaults for the circular FIFO with peek.
// ----------------------------------------------------------------------------
package cfp_pkg;

	localparam int DEPTH_DEF     = 256;
	localparam int ITEM_BITS_DEF = 8;

	localparam int CMD_W       = 2;
	localparam int STATUS_W    = 2;
	localparam int DATA_W      = 8;
	localparam int LEN_FIELD_W = 9;
	localparam int STEP_W      = $clog2(DATA_W);

	typedef logic [CMD_W-1:0]    cmd_t;
	typedef logic [STATUS_W-1:0] status_t;

	localparam cmd_t CMD_WRITE = 2'd0;
	localparam cmd_t CMD_READ  = 2'd1;
	localparam cmd_t CMD_PEEK  = 2'd2;
	localparam cmd_t CMD_CLEAR = 2'd3;

	localparam status_t ST_OK    = 2'd0;
	localparam status_t ST_FULL  = 2'd1;
	localparam status_t ST_EMPTY = 2'd2;

	// controller -> datapath
	typedef struct packed {
		logic              load;
		logic              mod_step;
		logic [STEP_W-1:0] mod_shift;
		logic              exec;
		logic              finish;
	} ctl_t;

	// datapath -> controller
	typedef struct packed {
		logic in_is_peek;
		logic out_free;
	} sts_t;

endpackage
`default_nettype wire

### rtl/cfp_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cfp_if
// Command and response channels of the circular FIFO with peek.
// ----------------------------------------------------------------------------
interface cfp_cmd_if;
	logic                     valid;
	logic                     ready;
	logic [1:0]               cmd;
	logic [7:0]               write_data;
	logic [7:0]               peek_position;

	modport source (output valid, cmd, write_data, peek_position, input ready);
	modport sink (input valid, cmd, write_data, peek_position, output ready);
endinterface

interface cfp_rsp_if;
	logic                     valid;
	logic                     ready;
	logic [1:0]               status;
	logic [7:0]               read_data;
	logic [7:0]               item_count;
	logic                     full_flag;
	logic                     empty_flag;

	modport source (output valid, status, read_data, item_count, full_flag, empty_flag,
		input ready);
	modport sink (input valid, status, read_data, item_count, full_flag, empty_flag,
		output ready);
endinterface
`default_nettype wire

### rtl/cfp_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cfp_ctrl
// Command sequencer: accept, peek modulo steps, slot access, result hand-off.
// ----------------------------------------------------------------------------
module cfp_ctrl (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         in_valid,
	output logic              in_ready,
	input  wire cfp_pkg::sts_t sts,
	output cfp_pkg::ctl_t     ctl
);
	import cfp_pkg::*;

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_MOD  = 2'd1;
	localparam logic [1:0] S_MEM  = 2'd2;
	localparam logic [1:0] S_DONE = 2'd3;

	localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(DATA_W - 1);

	logic [1:0]        state_q, state_nxt;
	logic [STEP_W-1:0] step_q;

	always_comb begin
		ctl           = '0;
		ctl.mod_shift = step_q;
		in_ready      = (state_q == S_IDLE);
		state_nxt     = state_q;
		unique case (state_q)
			S_IDLE: begin
				ctl.load = in_valid;
				if (in_valid) begin
					state_nxt = sts.in_is_peek ? S_MOD : S_MEM;
				end
			end
			S_MOD: begin
				ctl.mod_step = 1'b1;
				if (step_q == '0) begin
					state_nxt = S_MEM;
				end
			end
			S_MEM: begin
				ctl.exec  = 1'b1;
				state_nxt = S_DONE;
			end
			S_DONE: begin
				ctl.finish = sts.out_free;
				if (sts.out_free) begin
					state_nxt = S_IDLE;
				end
			end
			default: state_nxt = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			step_q  <= '0;
		end else begin
			state_q <= state_nxt;
			// remainder steps run from the top bit down
			if (ctl.load) begin
				step_q <= STEP_LAST;
			end else if (ctl.mod_step) begin
				step_q <= step_q - STEP_W'(1);
			end
		end
	end

	a_mem_then_done: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_MEM) |=> (state_q == S_DONE))
		else $error("slot access not followed by result stage");

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("second command taken while one is in flight");

	a_mod_then_mem: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == S_MOD) && (step_q == '0)) |=> (state_q == S_MEM))
		else $error("remainder steps not followed by slot access");

endmodule
`default_nettype wire

### rtl/cfp_datapath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cfp_datapath
// Ring indexes, slot store, peek remainder unit and result register.
// ----------------------------------------------------------------------------
module cfp_datapath #(
	parameter int DEPTH     = cfp_pkg::DEPTH_DEF,
	parameter int ITEM_BITS = cfp_pkg::ITEM_BITS_DEF
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               cfg_wr_en,
	input  wire logic [cfp_pkg::LEN_FIELD_W-1:0]    cfg_wr_data,
	input  wire cfp_pkg::cmd_t                      cmd,
	input  wire logic [cfp_pkg::DATA_W-1:0]         write_data,
	input  wire logic [cfp_pkg::DATA_W-1:0]         peek_position,
	input  wire cfp_pkg::ctl_t                      ctl,
	output cfp_pkg::sts_t                           sts,
	input  wire logic                               out_ready,
	output logic                                    out_valid,
	output cfp_pkg::status_t                        status,
	output logic [cfp_pkg::DATA_W-1:0]              read_data,
	output logic [cfp_pkg::DATA_W-1:0]              item_count,
	output logic                                    full_flag,
	output logic                                    empty_flag
);
	import cfp_pkg::*;

	localparam int IDX_W   = $clog2(DEPTH);
	localparam int HW_W    = IDX_W + 1;
	localparam int LEN_C_W = $clog2(DEPTH + 1);
	localparam int LEN_W   = (LEN_FIELD_W > LEN_C_W) ? LEN_FIELD_W : LEN_C_W;
	localparam int SH_W    = LEN_W + DATA_W - 1;

	localparam logic [LEN_W-1:0] LEN_MIN = LEN_W'(2);
	localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(DEPTH);

	logic [ITEM_BITS-1:0] mem [DEPTH];
	logic [ITEM_BITS-1:0] mem_rdata_q;

	logic [LEN_W-1:0]  len_q;
	logic [IDX_W-1:0]  wr_idx_q, rd_idx_q;
	logic [HW_W-1:0]   fill_q;      // slots below this mark have been written
	cmd_t              cmd_q;
	logic [DATA_W-1:0] wdata_q;
	logic [DATA_W-1:0] rem_q;
	status_t           status_q;
	logic              rvalid_q;
	logic              out_valid_q;

	logic [LEN_W-1:0]  len_in, len_clamped;
	logic [LEN_W-1:0]  nw_ext, nr_ext;
	logic [IDX_W-1:0]  next_wr, next_rd, rd_addr;
	logic              full_now, empty_now, mem_we, mem_re;
	logic [SH_W-1:0]   len_sh, rem_ext;
	logic [LEN_W-1:0]  wr_l, rd_l, count;

	always_comb begin
		len_in      = LEN_W'(cfg_wr_data);
		len_clamped = (len_in < LEN_MIN) ? LEN_MIN : ((len_in > LEN_MAX) ? LEN_MAX : len_in);

		nw_ext  = LEN_W'(wr_idx_q) + LEN_W'(1);
		nr_ext  = LEN_W'(rd_idx_q) + LEN_W'(1);
		next_wr = (nw_ext >= len_q) ? '0 : IDX_W'(nw_ext);
		next_rd = (nr_ext >= len_q) ? '0 : IDX_W'(nr_ext);

		full_now  = (next_wr == rd_idx_q);
		empty_now = (rd_idx_q == wr_idx_q);

		mem_we  = ctl.exec && (cmd_q == CMD_WRITE) && !full_now;
		mem_re  = ctl.exec && (((cmd_q == CMD_READ) && !empty_now) || (cmd_q == CMD_PEEK));
		rd_addr = (cmd_q == CMD_READ) ? rd_idx_q : IDX_W'(rem_q);

		len_sh  = SH_W'(len_q) << ctl.mod_shift;
		rem_ext = SH_W'(rem_q);

		wr_l  = LEN_W'(wr_idx_q);
		rd_l  = LEN_W'(rd_idx_q);
		count = (wr_l >= rd_l) ? (wr_l - rd_l) : (wr_l + len_q - rd_l);

		sts.in_is_peek = (cmd == CMD_PEEK);
		sts.out_free   = !out_valid_q || out_ready;
	end

	// slot store: one access per command
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[wr_idx_q] <= ITEM_BITS'(wdata_q);
		end
		if (mem_re) begin
			mem_rdata_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			cmd_q   <= cmd;
			wdata_q <= write_data;
		end
		// restoring remainder, one bit per step
		if (ctl.load) begin
			rem_q <= peek_position;
		end else if (ctl.mod_step && (rem_ext >= len_sh)) begin
			rem_q <= rem_q - len_sh[DATA_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q    <= LEN_MAX;
			wr_idx_q <= '0;
			rd_idx_q <= '0;
			fill_q   <= '0;
			status_q <= ST_OK;
			rvalid_q <= 1'b0;
		end else if (cfg_wr_en) begin
			len_q    <= len_clamped;
			wr_idx_q <= '0;
			rd_idx_q <= '0;
		end else if (ctl.exec) begin
			status_q <= ((cmd_q == CMD_WRITE) && full_now) ? ST_FULL :
				(((cmd_q == CMD_READ) && empty_now) ? ST_EMPTY : ST_OK);
			// slots at or past the fill mark are unwritten; their reads give zero
			rvalid_q <= mem_re && ({1'b0, rd_addr} < fill_q);
			unique case (cmd_q)
				CMD_WRITE: begin
					if (!full_now) begin
						wr_idx_q <= next_wr;
						if ({1'b0, wr_idx_q} == fill_q) begin
							fill_q <= fill_q + HW_W'(1);
						end
					end
				end
				CMD_READ: begin
					if (!empty_now) begin
						rd_idx_q <= next_rd;
					end
				end
				CMD_PEEK: begin
				end
				CMD_CLEAR: begin
					wr_idx_q <= '0;
					rd_idx_q <= '0;
				end
				default: begin
				end
			endcase
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctl.finish) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.finish) begin
			status     <= status_q;
			read_data  <= rvalid_q ? mem_rdata_q[DATA_W-1:0] : '0;
			item_count <= count[DATA_W-1:0];
			full_flag  <= full_now;
			empty_flag <= empty_now;
		end
	end

	assign out_valid = out_valid_q;

	a_wr_in_ring: assert property (@(posedge clk) disable iff (!arst_n)
		LEN_W'(wr_idx_q) < len_q)
		else $error("write index outside ring");

	a_rd_in_ring: assert property (@(posedge clk) disable iff (!arst_n)
		LEN_W'(rd_idx_q) < len_q)
		else $error("read index outside ring");

	a_fill_mark: assert property (@(posedge clk) disable iff (!arst_n)
		{1'b0, wr_idx_q} <= fill_q)
		else $error("write index past fill mark");

endmodule
`default_nettype wire

### rtl/circular_fifo_with_peek_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// circular_fifo_with_peek_top
// Byte FIFO in a ring of slots with one slot kept empty; write, read,
// peek and clear commands, one result per command.
// ----------------------------------------------------------------------------
//  channel   dir  handshake      payload
//  cmd_ch    in   valid/ready    cmd, write_data, peek_position
//  rsp_ch    out  valid/ready    status, read_data, item_count, full_flag, empty_flag
//  cfg       in   cfg_wr_en      cfg_wr_data (buffer length)
//
// Write, read and clear pass from transfer through slot access to result;
// peek first runs the bit-serial remainder of the position by the length.
// One command is in flight at a time; the next is taken once its result
// sits in the output register, even while that result waits for rsp_ch.ready.
// Reset needs no clearing pass: a fill mark makes unwritten slots read as zero.
// ----------------------------------------------------------------------------
module circular_fifo_with_peek_top #(
	parameter int DEPTH     = cfp_pkg::DEPTH_DEF,
	parameter int ITEM_BITS = cfp_pkg::ITEM_BITS_DEF
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            cfg_wr_en,
	input  wire logic [cfp_pkg::LEN_FIELD_W-1:0] cfg_wr_data,
	cfp_cmd_if.sink                              cmd_ch,
	cfp_rsp_if.source                            rsp_ch
);
	import cfp_pkg::*;

	ctl_t ctl;
	sts_t sts;
	logic in_ready;

	assign cmd_ch.ready = in_ready;

	cfp_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (cmd_ch.valid),
		.in_ready (in_ready),
		.sts      (sts),
		.ctl      (ctl)
	);

	cfp_datapath #(
		.DEPTH     (DEPTH),
		.ITEM_BITS (ITEM_BITS)
	) u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_wr_data   (cfg_wr_data),
		.cmd           (cmd_ch.cmd),
		.write_data    (cmd_ch.write_data),
		.peek_position (cmd_ch.peek_position),
		.ctl           (ctl),
		.sts           (sts),
		.out_ready     (rsp_ch.ready),
		.out_valid     (rsp_ch.valid),
		.status        (rsp_ch.status),
		.read_data     (rsp_ch.read_data),
		.item_count    (rsp_ch.item_count),
		.full_flag     (rsp_ch.full_flag),
		.empty_flag    (rsp_ch.empty_flag)
	);

endmodule
`default_nettype wire
